FILE: sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = 10;
  localparam int ADDR_W       = 10;
  localparam int POS_W        = 24;
  localparam int ACC_W        = 24;
  localparam int NRM_W        = 16;
  localparam int VEC_W        = 52;

  localparam logic [IDX_W:0] VTX_LIMIT = (IDX_W + 1)'(MAX_VERTICES);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FACE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                    op;
    logic                    ok;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [IDX_W-1:0]        ca;
    logic [IDX_W-1:0]        cb;
    logic [IDX_W-1:0]        cc;
  } req_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;
  } unit_req_t;

  typedef struct packed {
    logic                    done;
    logic                    zero;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } unit_res_t;

endpackage

FILE: sv/vna_front.sv
// ----------------------------------------------------------------------------
// vna_front
// Takes requests, checks index ranges and queues them for the back end.
// ----------------------------------------------------------------------------
module vna_front import vna_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              command,
  input  logic [IDX_W-1:0]        vertex_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IDX_W-1:0]        corner_a,
  input  logic [IDX_W-1:0]        corner_b,
  input  logic [IDX_W-1:0]        corner_c,
  input  logic                    hold,
  output logic                    req_valid,
  output req_t                    req,
  input  logic                    req_take
);

  req_t       in_req;
  req_t       slot [2];
  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  logic       accept;

  function automatic logic in_range(input logic [IDX_W-1:0] i);
    return {1'b0, i} < VTX_LIMIT;
  endfunction

  always_comb begin
    in_req.op  = cmd_t'(command);
    in_req.idx = vertex_index;
    in_req.px  = pos_x;
    in_req.py  = pos_y;
    in_req.pz  = pos_z;
    in_req.ca  = corner_a;
    in_req.cb  = corner_b;
    in_req.cc  = corner_c;
    unique case (in_req.op) inside
      CMD_WRITE, CMD_READ: in_req.ok = in_range(vertex_index);
      CMD_FACE: begin
        in_req.ok = in_range(corner_a) & in_range(corner_b) & in_range(corner_c);
      end
      default: in_req.ok = 1'b1;
    endcase
  end

  assign full      = (cnt == 2'd2) | hold;
  assign accept    = push & ~full;
  assign req_valid = cnt != 2'd0;
  assign req       = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (accept) wp <= ~wp;
      if (req_take) rp <= ~rp;
      case ({accept, req_take})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) slot[wp] <= in_req;
  end

endmodule

FILE: sv/vna_unit.sv
// ----------------------------------------------------------------------------
// vna_unit
// Iterative unit vector: align to 20 bits, sum of squares, bitwise square
// root, then one restoring division per component into Q1.14.
// ----------------------------------------------------------------------------
module vna_unit import vna_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  unit_req_t ureq,
  output unit_res_t ures
);

  typedef enum logic [2:0] {
    U_IDLE, U_MAX, U_NORM, U_SQ, U_ROOT, U_DIVI, U_DIV
  } state_t;

  state_t                  state;
  logic signed [VEC_W-1:0] v [3];
  logic [VEC_W-1:0]        mag [3];
  logic                    neg [3];
  logic [VEC_W-1:0]        m;
  logic [VEC_W-1:0]        mmax;
  logic [4:0]              cnt;
  logic [1:0]              k;
  logic [39:0]             prod;
  logic [41:0]             sum;
  logic [41:0]             sum_next;
  logic [43:0]             rad;
  logic [25:0]             rem;
  logic [25:0]             rem_sh;
  logic [25:0]             trial;
  logic [21:0]             root;
  logic [36:0]             num;
  logic [36:0]             dsh;
  logic [14:0]             q;
  logic [14:0]             q_new;
  logic                    ge;
  logic [19:0]             sq_in;
  logic [19:0]             dv_in;
  logic signed [NRM_W-1:0] n [3];
  logic                    done;
  logic                    zero;

  always_comb begin
    v[0] = ureq.vx;
    v[1] = ureq.vy;
    v[2] = ureq.vz;
    mmax = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mmax) mmax = mag[2];
    case (cnt[1:0])
      2'd0:    sq_in = mag[0][19:0];
      2'd1:    sq_in = mag[1][19:0];
      default: sq_in = mag[2][19:0];
    endcase
    case (k)
      2'd0:    dv_in = mag[0][19:0];
      2'd1:    dv_in = mag[1][19:0];
      default: dv_in = mag[2][19:0];
    endcase
    sum_next = sum + 42'(prod);
    rem_sh   = {rem[23:0], rad[43:42]};
    trial    = {2'b00, root, 2'b01};
    ge       = num >= dsh;
    q_new    = {q[13:0], ge};
  end

  assign ures.done = done;
  assign ures.zero = zero;
  assign ures.nx   = n[0];
  assign ures.ny   = n[1];
  assign ures.nz   = n[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (ureq.start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= v[i][VEC_W-1];
              mag[i] <= v[i][VEC_W-1] ? VEC_W'(-v[i]) : VEC_W'(v[i]);
            end
            state <= U_MAX;
          end
        end
        U_MAX: begin
          m <= mmax;
          if (mmax == '0) begin
            zero  <= 1'b1;
            n[0]  <= '0;
            n[1]  <= '0;
            n[2]  <= '0;
            done  <= 1'b1;
            state <= U_IDLE;
          end else begin
            zero  <= 1'b0;
            state <= U_NORM;
          end
        end
        U_NORM: begin
          if (|m[VEC_W-1:20]) begin
            m <= m >> 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!m[19]) begin
            m <= m << 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            cnt   <= '0;
            sum   <= '0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          if (cnt != 5'd3) prod <= sq_in * sq_in;
          if (cnt != 5'd0) sum <= sum_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            rad   <= {2'b00, sum_next};
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= U_ROOT;
          end
        end
        U_ROOT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[20:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[20:0], 1'b0};
          end
          rad <= rad << 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd21) begin
            k     <= 2'd0;
            state <= U_DIVI;
          end
        end
        U_DIVI: begin
          num   <= 37'({dv_in, 15'b0}) + 37'(root);
          dsh   <= {root, 1'b0, 14'b0};
          q     <= '0;
          cnt   <= '0;
          state <= U_DIV;
        end
        U_DIV: begin
          if (ge) num <= num - dsh;
          q   <= q_new;
          dsh <= dsh >> 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd14) begin
            n[k] <= neg[k] ? -signed'({1'b0, q_new}) : signed'({1'b0, q_new});
            if (k == 2'd2) begin
              done  <= 1'b1;
              state <= U_IDLE;
            end else begin
              k     <= k + 2'd1;
              state <= U_DIVI;
            end
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/vna_back.sv
// ----------------------------------------------------------------------------
// vna_back
// Sequencer with position and accumulator memories: face normals, flip
// test, saturating accumulation, reads, clears and the result register.
// ----------------------------------------------------------------------------
module vna_back import vna_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  req_t                    req,
  output logic                    req_take,
  output logic                    hold,
  output unit_req_t               ureq,
  input  unit_res_t               ures,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    status
);

  typedef enum logic [4:0] {
    B_INIT, B_IDLE, B_CLEAR, B_WRITE, B_PA, B_PB, B_PC, B_PD, B_EDGE, B_CROSS,
    B_USTART, B_UWAIT, B_DOT, B_FLIP, B_AREAD, B_AWRITE, B_RREAD, B_RSTART,
    B_RWAIT, B_RESP
  } state_t;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(MAX_VERTICES - 1);

  logic [3*POS_W-1:0] pmem [MAX_VERTICES];
  logic [3*ACC_W-1:0] amem [MAX_VERTICES];

  state_t                  state;
  req_t                    cur;
  logic [ADDR_W-1:0]       cnt;
  logic [1:0]              k;
  logic [3*POS_W-1:0]      prd;
  logic [3*ACC_W-1:0]      ard;
  logic [ADDR_W-1:0]       paddr;
  logic [ADDR_W-1:0]       aaddr;
  logic                    pwe;
  logic                    awe;
  logic [3*ACC_W-1:0]      awdata;
  logic [IDX_W-1:0]        corner;
  logic signed [POS_W-1:0] pv [3];
  logic signed [POS_W-1:0] pa [3];
  logic signed [POS_W-1:0] pb [3];
  logic signed [POS_W-1:0] pc [3];
  logic signed [POS_W:0]   e0 [3];
  logic signed [POS_W:0]   e1 [3];
  logic signed [POS_W+1:0] s [3];
  logic signed [VEC_W-1:0] cr [3];
  logic signed [POS_W:0]   ma;
  logic signed [POS_W:0]   mb;
  logic signed [2*POS_W+1:0] prod;
  logic [2:0]              pidx;
  logic signed [NRM_W-1:0] nv [3];
  logic signed [NRM_W-1:0] da;
  logic signed [POS_W+1:0] db;
  logic signed [NRM_W+POS_W+1:0] prod2;
  logic signed [NRM_W+POS_W+3:0] dot;
  logic signed [NRM_W-1:0] res_n [3];
  logic                    res_st;
  logic                    out_valid;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [NRM_W-1:0] d
  );
    logic signed [ACC_W:0] t;
    t = (ACC_W + 1)'(a) + (ACC_W + 1)'(d);
    if (t[ACC_W] != t[ACC_W-1]) begin
      return t[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end
    return t[ACC_W-1:0];
  endfunction

  always_comb begin
    pv[0] = prd[3*POS_W-1:2*POS_W];
    pv[1] = prd[2*POS_W-1:POS_W];
    pv[2] = prd[POS_W-1:0];
    case (k)
      2'd0:    corner = cur.ca;
      2'd1:    corner = cur.cb;
      default: corner = cur.cc;
    endcase
    case (state)
      B_PA:    paddr = cur.ca[ADDR_W-1:0];
      B_PB:    paddr = cur.cb[ADDR_W-1:0];
      B_PC:    paddr = cur.cc[ADDR_W-1:0];
      default: paddr = cur.idx[ADDR_W-1:0];
    endcase
    case (state)
      B_INIT, B_CLEAR:  aaddr = cnt;
      B_AREAD, B_AWRITE: aaddr = corner[ADDR_W-1:0];
      default:          aaddr = cur.idx[ADDR_W-1:0];
    endcase
    pwe = (state == B_WRITE) & cur.ok;
    awe = (state == B_INIT) | (state == B_CLEAR) | (state == B_AWRITE);
    if (state == B_AWRITE) begin
      awdata = {sat_add(ard[3*ACC_W-1:2*ACC_W], nv[0]),
                sat_add(ard[2*ACC_W-1:ACC_W], nv[1]),
                sat_add(ard[ACC_W-1:0], nv[2])};
    end else begin
      awdata = '0;
    end
    case (cnt[2:0])
      3'd0:    begin ma = e0[1]; mb = e1[2]; end
      3'd1:    begin ma = e0[2]; mb = e1[1]; end
      3'd2:    begin ma = e0[2]; mb = e1[0]; end
      3'd3:    begin ma = e0[0]; mb = e1[2]; end
      3'd4:    begin ma = e0[0]; mb = e1[1]; end
      default: begin ma = e0[1]; mb = e1[0]; end
    endcase
    pidx = cnt[2:0] - 3'd1;
    case (cnt[1:0])
      2'd0:    begin da = nv[0]; db = s[0]; end
      2'd1:    begin da = nv[1]; db = s[1]; end
      default: begin da = nv[2]; db = s[2]; end
    endcase
    ureq.start = (state == B_USTART) | (state == B_RSTART);
    if (state == B_RSTART) begin
      ureq.vx = VEC_W'(signed'(ard[3*ACC_W-1:2*ACC_W]));
      ureq.vy = VEC_W'(signed'(ard[2*ACC_W-1:ACC_W]));
      ureq.vz = VEC_W'(signed'(ard[ACC_W-1:0]));
    end else begin
      ureq.vx = cr[0];
      ureq.vy = cr[1];
      ureq.vz = cr[2];
    end
  end

  assign req_take = (state == B_IDLE) & req_valid;
  assign hold     = state == B_INIT;
  assign empty    = ~out_valid;

  always_ff @(posedge clk) begin
    prd <= pmem[paddr];
    if (pwe) pmem[paddr] <= {cur.px, cur.py, cur.pz};
  end

  always_ff @(posedge clk) begin
    ard <= amem[aaddr];
    if (awe) amem[aaddr] <= awdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop & out_valid) out_valid <= 1'b0;
      unique case (state)
        B_INIT: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == LAST) state <= B_IDLE;
        end
        B_IDLE: begin
          if (req_valid) begin
            cur      <= req;
            res_n[0] <= '0;
            res_n[1] <= '0;
            res_n[2] <= '0;
            res_st   <= 1'b0;
            cnt      <= '0;
            k        <= 2'd0;
            unique case (req.op)
              CMD_WRITE: state <= B_WRITE;
              CMD_FACE:  state <= req.ok ? B_PA : B_RESP;
              CMD_READ: begin
                if (req.ok) state <= B_RREAD;
                else begin
                  res_st <= 1'b1;
                  state  <= B_RESP;
                end
              end
              default: state <= B_CLEAR;
            endcase
          end
        end
        B_CLEAR: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == LAST) state <= B_RESP;
        end
        B_WRITE: state <= B_RESP;
        B_PA: state <= B_PB;
        B_PB: begin
          pa    <= pv;
          state <= B_PC;
        end
        B_PC: begin
          pb    <= pv;
          state <= B_PD;
        end
        B_PD: begin
          pc    <= pv;
          state <= B_EDGE;
        end
        B_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            e0[i] <= (POS_W + 1)'(pb[i]) - (POS_W + 1)'(pa[i]);
            e1[i] <= (POS_W + 1)'(pc[i]) - (POS_W + 1)'(pa[i]);
            s[i]  <= (POS_W + 2)'(pa[i]) + (POS_W + 2)'(pb[i]) + (POS_W + 2)'(pc[i]);
            cr[i] <= '0;
          end
          cnt   <= '0;
          state <= B_CROSS;
        end
        B_CROSS: begin
          prod <= ma * mb;
          if (cnt[2:0] != 3'd0) begin
            if (pidx[0]) cr[pidx[2:1]] <= cr[pidx[2:1]] - VEC_W'(prod);
            else         cr[pidx[2:1]] <= cr[pidx[2:1]] + VEC_W'(prod);
          end
          cnt <= cnt + ADDR_W'(1);
          if (cnt[2:0] == 3'd6) state <= B_USTART;
        end
        B_USTART: state <= B_UWAIT;
        B_UWAIT: begin
          if (ures.done) begin
            if (ures.zero) state <= B_RESP;
            else begin
              nv[0] <= ures.nx;
              nv[1] <= ures.ny;
              nv[2] <= ures.nz;
              cnt   <= '0;
              dot   <= '0;
              state <= B_DOT;
            end
          end
        end
        B_DOT: begin
          if (cnt[1:0] != 2'd3) prod2 <= da * db;
          if (cnt[1:0] != 2'd0) dot <= dot + (NRM_W + POS_W + 4)'(prod2);
          cnt <= cnt + ADDR_W'(1);
          if (cnt[1:0] == 2'd3) state <= B_FLIP;
        end
        B_FLIP: begin
          if (dot < 0) begin
            nv[0] <= -nv[0];
            nv[1] <= -nv[1];
            nv[2] <= -nv[2];
          end
          k     <= 2'd0;
          state <= B_AREAD;
        end
        B_AREAD: state <= B_AWRITE;
        B_AWRITE: begin
          if (k == 2'd2) state <= B_RESP;
          else begin
            k     <= k + 2'd1;
            state <= B_AREAD;
          end
        end
        B_RREAD: state <= B_RSTART;
        B_RSTART: state <= B_RWAIT;
        B_RWAIT: begin
          if (ures.done) begin
            res_n[0] <= ures.nx;
            res_n[1] <= ures.ny;
            res_n[2] <= ures.nz;
            res_st   <= ures.zero;
            state    <= B_RESP;
          end
        end
        B_RESP: begin
          if (!out_valid) begin
            normal_x  <= res_n[0];
            normal_y  <= res_n[1];
            normal_z  <= res_n[2];
            status    <= res_st;
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/vertex_normal_accumulate_top.sv
// The back end handles one request at a time. For faces and reads, most of
// its time goes to the normalizer's alignment shifts, 22-step square root
// and three 15-step divisions.
// Reset: synchronous; afterwards a sweep zeroes every accumulator memory entry,
// one entry per cycle, with full held high. Clear uses the same sweep.
// ----------------------------------------------------------------------------
// vertex_normal_accumulate_top
// Vertex position table with per-vertex face normal accumulators.
// ----------------------------------------------------------------------------
module vertex_normal_accumulate_top import vna_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              command,
  input  logic [IDX_W-1:0]        vertex_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IDX_W-1:0]        corner_a,
  input  logic [IDX_W-1:0]        corner_b,
  input  logic [IDX_W-1:0]        corner_c,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    status
);

  logic      hold;
  logic      req_valid;
  logic      req_take;
  req_t      req;
  unit_req_t ureq;
  unit_res_t ures;

  vna_front u_front (
    .clk, .rst, .push, .full, .command, .vertex_index, .pos_x, .pos_y, .pos_z,
    .corner_a, .corner_b, .corner_c, .hold, .req_valid, .req, .req_take
  );

  vna_unit u_unit (.clk, .rst, .ureq, .ures);

  vna_back u_back (
    .clk, .rst, .req_valid, .req, .req_take, .hold, .ureq, .ures,
    .empty, .pop, .normal_x, .normal_y, .normal_z, .status
  );

endmodule
